// ===== sv/cllc_pkg.sv =====
// Package for the clamped linear LUT cache: widths, codes and table math.
// Used by every module of the block; depends on nothing.
package cllc_pkg;

  localparam int unsigned CAPACITY_DEF = 256;
  localparam int unsigned TABLE_SIZE   = 256;
  localparam int unsigned SCALE_W      = 20;
  localparam int unsigned OFFSET_W     = 18;
  localparam int unsigned STAMP_W      = 31;
  localparam int unsigned IDX_W        = 8;

  localparam logic [SCALE_W-1:0]  SCALE_ONE   = 20'd4096;
  localparam logic [STAMP_W-1:0]  STAMP_MAX   = 31'h7FFF_FFFF;
  localparam logic [STAMP_W-1:0]  STAMP_LIMIT = 31'h4000_0000;

  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_TIDY   = 1'b1;

  localparam logic [1:0] ST_BYPASS = 2'd0;
  localparam logic [1:0] ST_HIT    = 2'd1;
  localparam logic [1:0] ST_MISS   = 2'd2;
  localparam logic [1:0] ST_TIDY   = 2'd3;

  // Request carried down the tag chain
  typedef struct packed {
    logic               active;
    logic [SCALE_W-1:0]  scale;
    logic [OFFSET_W-1:0] offset;
  } probe_t;

  // Running search result carried down the tag chain
  typedef struct packed {
    logic               hit;
    logic               free_found;
    logic [10:0]        hit_idx;
    logic [10:0]        free_idx;
    logic [10:0]        lru_idx;
    logic [STAMP_W-1:0] lru_stamp;
  } search_t;

  // Clamp the 12-fraction-bit sum to a byte
  function automatic logic [7:0] clamp_byte(input logic signed [30:0] sum);
    logic [18:0] q;
    q = sum[30:12];
    if (sum[30]) return 8'd0;
    else if (q > 19'd255) return 8'd255;
    else return q[7:0];
  endfunction

endpackage

// ===== sv/clamped_linear_lut_cache_core.sv =====
// Top level of the clamped linear LUT cache: sequencer, tag cell row, table memory.
// Depends on cllc_pkg, cllc_tag_cell and cllc_table_mem.
//
// One transaction at a time. A bypass or tidy result is valid the cycle after
// acceptance. A lookup runs the probe down the row of CAPACITY tag cells, one
// cell per cycle; a hit then reads its table byte (states S_READ, S_DATA). A
// miss first fills the slot's 256 table bytes through the single memory write
// port, one byte per cycle, and then reads its byte the same way. The result
// sits in an output register and the next transaction is taken only in the
// cycle that result leaves (or once it has left). No clearing pass is needed.
module clamped_linear_lut_cache_core #(
  parameter int unsigned CAPACITY = cllc_pkg::CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [0] command, [20:1] scale, [38:21] offset, [46:39] component, [47] zero
  input  logic [47:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] mapped_value, [9:8] status, [17:10] slot, [18] cleared, [23:19] zero
  output logic [23:0] out_tdata
);
  localparam int unsigned SW = $clog2(CAPACITY);
  localparam int unsigned AW = SW + 8;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_WALK  = 6'b000010,
    S_FILL  = 6'b000100,
    S_READ  = 6'b001000,
    S_DATA  = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic [cllc_pkg::STAMP_W-1:0]  stamp_r;
  logic [cllc_pkg::SCALE_W-1:0]  scale_r;
  logic [cllc_pkg::OFFSET_W-1:0] offset_r;
  logic [7:0]  comp_r;
  logic [SW-1:0] slot_r;
  logic [1:0]  status_r;
  logic [8:0]  cnt_r;
  logic signed [30:0] acc_r;
  logic        ovalid_r;
  logic [23:0] odata_r;

  cllc_pkg::probe_t  probe  [CAPACITY+1];
  cllc_pkg::search_t search [CAPACITY+1];
  logic [CAPACITY-1:0] wr_vec;
  logic [CAPACITY-1:0] touch_vec;
  logic clear_all;

  logic in_fire, out_fire, is_tidy, is_bypass;
  logic [7:0] rd_data;
  logic mem_we;
  logic [AW-1:0] wr_addr, rd_addr;

  assign in_fire   = in_tvalid && in_tready;
  assign out_fire  = out_tvalid && out_tready;
  assign in_tready = (state_r == S_IDLE) && !(ovalid_r && !out_tready);
  assign is_tidy   = in_tdata[0] == cllc_pkg::CMD_TIDY;
  assign is_bypass = in_tdata[20:1] == cllc_pkg::SCALE_ONE && in_tdata[38:21] == '0;
  assign clear_all = in_fire && is_tidy && stamp_r > cllc_pkg::STAMP_LIMIT;

  // Feed the tag row head; hold the accepted key behind the probe
  assign probe[0].active  = in_fire && !is_tidy && !is_bypass;
  assign probe[0].scale   = in_fire ? in_tdata[20:1] : scale_r;
  assign probe[0].offset  = in_fire ? in_tdata[38:21] : offset_r;
  assign search[0]        = '0;

  // Build the tag cell row
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    cllc_tag_cell #(.IDX(g)) u_cell (
      .clk(clk), .rst_n(rst_n),
      .probe_i(probe[g]), .search_i(search[g]),
      .wr_en(wr_vec[g]), .touch_en(touch_vec[g]), .clear_all(clear_all),
      .stamp(stamp_r),
      .probe_o(probe[g+1]), .search_o(search[g+1])
    );
  end

  // Write or touch the chosen slot when the search leaves the row
  logic [SW-1:0] pick;
  always_comb begin
    pick = search[CAPACITY].hit ? search[CAPACITY].hit_idx[SW-1:0] :
           search[CAPACITY].free_found ? search[CAPACITY].free_idx[SW-1:0] :
           search[CAPACITY].lru_idx[SW-1:0];
    wr_vec = '0;
    touch_vec = '0;
    if (probe[CAPACITY].active) begin
      if (search[CAPACITY].hit) touch_vec[pick] = 1'b1;
      else                      wr_vec[pick]    = 1'b1;
    end
  end

  assign mem_we  = state_r == S_FILL;
  assign wr_addr = {slot_r, cnt_r[7:0]};
  assign rd_addr = {slot_r, comp_r};

  cllc_table_mem #(.CAPACITY(CAPACITY), .AW(AW)) u_mem (
    .clk(clk), .wr_en(mem_we), .wr_addr(wr_addr),
    .wr_data(cllc_pkg::clamp_byte(acc_r)), .rd_addr(rd_addr), .rd_data(rd_data)
  );

  // Sequence one transaction
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (probe[0].active) state_nxt = S_WALK;
      S_WALK: if (probe[CAPACITY].active)
                state_nxt = search[CAPACITY].hit ? S_READ : S_FILL;
      S_FILL: if (cnt_r == 9'(cllc_pkg::TABLE_SIZE - 1)) state_nxt = S_READ;
      S_READ: state_nxt = S_DATA;
      S_DATA: state_nxt = S_OUT;
      S_OUT:  if (!ovalid_r || out_tready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      stamp_r  <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // Launch a result, or drop the one just taken
      if ((in_fire && (is_tidy || is_bypass)) ||
          (state_r == S_OUT && (!ovalid_r || out_tready)))
        ovalid_r <= 1'b1;
      else if (out_fire)
        ovalid_r <= 1'b0;
      // Restart the stamp on a clearing tidy, advance it on a cached lookup
      if (clear_all)
        stamp_r <= 31'd1;
      else if (probe[0].active && stamp_r != cllc_pkg::STAMP_MAX)
        stamp_r <= stamp_r + 31'd1;
    end
  end

  // Hold the payload and step the fill accumulator
  always_ff @(posedge clk) begin
    if (in_fire) begin
      scale_r  <= in_tdata[20:1];
      offset_r <= in_tdata[38:21];
      comp_r   <= in_tdata[46:39];
      if (is_tidy)
        odata_r <= {5'd0, clear_all, 8'd0, cllc_pkg::ST_TIDY, 8'd0};
      else if (is_bypass)
        odata_r <= {5'd0, 1'b0, 8'd0, cllc_pkg::ST_BYPASS, in_tdata[46:39]};
    end
    if (state_r == S_WALK && probe[CAPACITY].active) begin
      slot_r   <= pick;
      status_r <= search[CAPACITY].hit ? cllc_pkg::ST_HIT : cllc_pkg::ST_MISS;
      cnt_r    <= '0;
      acc_r    <= 31'(signed'({offset_r, 4'd0}));
    end
    if (state_r == S_FILL) begin
      cnt_r <= cnt_r + 9'd1;
      acc_r <= acc_r + 31'(signed'(scale_r));
    end
    if (state_r == S_DATA)
      odata_r <= {5'd0, 1'b0, 8'(slot_r), status_r, rd_data};
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;

  // A probe leaves the tag row only during the walk
  a_walk_only: assert property (@(posedge clk) disable iff (!rst_n)
    probe[CAPACITY].active |-> state_r == S_WALK) else $error("probe outside walk");
  // A miss fill never writes while the input is ready
  a_fill_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> !in_tready) else $error("fill while ready");
  // Stamp never wraps to zero after leaving reset
  a_stamp: assert property (@(posedge clk) disable iff (!rst_n)
    $past(stamp_r) != 31'd0 |-> stamp_r != 31'd0) else $error("stamp wrapped");
endmodule

// ===== sv/cllc_tag_cell.sv =====
// One tag cell of the cache: key, valid bit and use stamp of a slot.
// Depends on cllc_pkg; chained by the top level into the search row.
module cllc_tag_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  cllc_pkg::probe_t           probe_i,
  input  cllc_pkg::search_t          search_i,
  input  logic                       wr_en,
  input  logic                       touch_en,
  input  logic                       clear_all,
  input  logic [cllc_pkg::STAMP_W-1:0] stamp,
  output cllc_pkg::probe_t           probe_o,
  output cllc_pkg::search_t          search_o
);
  logic                          valid_r;
  logic [cllc_pkg::SCALE_W-1:0]  scale_r;
  logic [cllc_pkg::OFFSET_W-1:0] offset_r;
  logic [cllc_pkg::STAMP_W-1:0]  used_r;
  cllc_pkg::search_t             res;
  logic                          match;

  // Update this slot's stored key and stamp
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (clear_all) begin
      valid_r <= 1'b0;
    end else if (wr_en) begin
      valid_r <= 1'b1;
    end
    if (wr_en) begin
      scale_r  <= probe_i.scale;
      offset_r <= probe_i.offset;
    end
    if (wr_en || touch_en) used_r <= stamp;
  end

  // Fold this slot into the running search; first match and first free slot win, lowest index wins a stamp tie
  assign match = valid_r && scale_r == probe_i.scale && offset_r == probe_i.offset;
  always_comb begin
    res = search_i;
    if (match && !search_i.hit) begin
      res.hit     = 1'b1;
      res.hit_idx = 11'(IDX);
    end
    if (!valid_r && !search_i.free_found) begin
      res.free_found = 1'b1;
      res.free_idx   = 11'(IDX);
    end
    if (IDX == 0 || used_r < search_i.lru_stamp) begin
      res.lru_idx   = 11'(IDX);
      res.lru_stamp = used_r;
    end
  end

  // Register the hand-off to the next cell
  always_ff @(posedge clk) begin
    if (!rst_n) probe_o.active <= 1'b0;
    else        probe_o.active <= probe_i.active;
    probe_o.scale  <= probe_i.scale;
    probe_o.offset <= probe_i.offset;
    search_o       <= res;
  end
endmodule

// ===== sv/cllc_table_mem.sv =====
// Table byte memory: one row of TABLE_SIZE bytes per cache slot.
// Depends on cllc_pkg; one write and one registered read port.
module cllc_table_mem #(
  parameter int unsigned CAPACITY = cllc_pkg::CAPACITY_DEF,
  parameter int unsigned AW = $clog2(CAPACITY) + 8
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);
  logic [7:0] mem [CAPACITY*cllc_pkg::TABLE_SIZE];

  // Write and read the byte store
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end
endmodule

// ===== tb/tb_clamped_linear_lut_cache_core.sv =====
// Testbench for clamped_linear_lut_cache_core: directed and random lookups and tidies,
// checked against a behavioral LUT cache predictor. Depends on cllc_pkg and the core RTL.
module tb_clamped_linear_lut_cache_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CAP = cllc_pkg::CAPACITY_DEF;
  localparam int unsigned CYCLE_LIMIT = 3000000;

  typedef struct packed {
    logic        cleared;
    logic [7:0]  slot;
    logic [1:0]  status;
    logic [7:0]  mapped_value;
  } lut_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;

  // Predictor state
  logic [cllc_pkg::SCALE_W-1:0]  cache_scale [CAP];
  logic [cllc_pkg::OFFSET_W-1:0] cache_offset [CAP];
  logic                          cache_valid [CAP];
  logic [cllc_pkg::STAMP_W-1:0]  cache_stamp [CAP];
  logic [cllc_pkg::STAMP_W-1:0]  stamp_now;

  lut_result_t pending_results [$];
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  bit          calm = 1'b0;

  // Keys seen recently, reused to produce hits
  logic [cllc_pkg::SCALE_W-1:0]  recent_scale [$];
  logic [cllc_pkg::OFFSET_W-1:0] recent_offset [$];

  clamped_linear_lut_cache_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always #4 clk = ~clk;

  // Map one component through the clamped line
  function automatic logic [7:0] line_value(logic [cllc_pkg::SCALE_W-1:0] sc,
                                            logic [cllc_pkg::OFFSET_W-1:0] off,
                                            logic [7:0] comp);
    longint sum;
    longint q;
    sum = longint'(comp) * longint'($signed(sc)) + longint'($signed(off)) * 16;
    if (sum < 0) return 8'd0;
    q = sum >>> 12;
    return (q > 255) ? 8'd255 : q[7:0];
  endfunction

  // Advance the cache model by one transaction and return its result
  function automatic lut_result_t predict_lookup(logic cmd, logic [cllc_pkg::SCALE_W-1:0] sc,
                                                 logic [cllc_pkg::OFFSET_W-1:0] off,
                                                 logic [7:0] comp);
    lut_result_t r;
    int idx;
    bit found;
    r = '0;
    if (cmd == cllc_pkg::CMD_TIDY) begin
      r.status = cllc_pkg::ST_TIDY;
      if (stamp_now > cllc_pkg::STAMP_LIMIT) begin
        stamp_now = 31'd1;
        for (int i = 0; i < CAP; i++) cache_valid[i] = 1'b0;
        r.cleared = 1'b1;
      end
      return r;
    end
    if (sc == cllc_pkg::SCALE_ONE && off == '0) begin
      r.status = cllc_pkg::ST_BYPASS;
      r.mapped_value = comp;
      return r;
    end
    if (stamp_now < cllc_pkg::STAMP_MAX) stamp_now++;
    found = 1'b0;
    idx = 0;
    for (int i = 0; i < CAP; i++) begin
      if (!found && cache_valid[i] && cache_scale[i] == sc && cache_offset[i] == off) begin
        idx = i;
        found = 1'b1;
      end
    end
    if (found) begin
      r.status = cllc_pkg::ST_HIT;
    end else begin
      bit free_found;
      free_found = 1'b0;
      for (int i = 0; i < CAP; i++) begin
        if (!free_found && !cache_valid[i]) begin
          idx = i;
          free_found = 1'b1;
        end
      end
      // Evict the oldest stamp, lowest index on a tie
      if (!free_found) begin
        idx = 0;
        for (int i = 1; i < CAP; i++)
          if (cache_stamp[i] < cache_stamp[idx]) idx = i;
      end
      cache_valid[idx] = 1'b1;
      cache_scale[idx] = sc;
      cache_offset[idx] = off;
      r.status = cllc_pkg::ST_MISS;
    end
    cache_stamp[idx] = stamp_now;
    r.mapped_value = line_value(sc, off, comp);
    r.slot = idx[7:0];
    return r;
  endfunction

  // Drive one transaction, wait for acceptance, record its expected result
  task automatic send_item(logic cmd, logic [cllc_pkg::SCALE_W-1:0] sc,
                           logic [cllc_pkg::OFFSET_W-1:0] off, logic [7:0] comp);
    bit rdy;
    while (!calm && $urandom_range(0, 99) < 28) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {1'b0, comp, off, sc, cmd};
    do begin
      @(negedge clk);
      rdy = in_tready;
      @(posedge clk);
    end while (!rdy);
    pending_results.push_back(predict_lookup(cmd, sc, off, comp));
    if (cmd == cllc_pkg::CMD_LOOKUP && !(sc == cllc_pkg::SCALE_ONE && off == '0)) begin
      recent_scale.push_back(sc);
      recent_offset.push_back(off);
      if (recent_scale.size() > 16) begin
        void'(recent_scale.pop_front());
        void'(recent_offset.pop_front());
      end
    end
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Extremes, bypass, hit, miss and tidy below the stamp limit
  task automatic test_directed();
    send_item(cllc_pkg::CMD_LOOKUP, cllc_pkg::SCALE_ONE, 18'd0, 8'd0);
    send_item(cllc_pkg::CMD_LOOKUP, cllc_pkg::SCALE_ONE, 18'd0, 8'd255);
    send_item(cllc_pkg::CMD_LOOKUP, cllc_pkg::SCALE_ONE, 18'd1, 8'd77);
    send_item(cllc_pkg::CMD_LOOKUP, 20'h80000, 18'h1FFFF, 8'd0);
    send_item(cllc_pkg::CMD_LOOKUP, 20'h80000, 18'h1FFFF, 8'd255);
    send_item(cllc_pkg::CMD_LOOKUP, 20'h7FFFF, 18'h20000, 8'd255);
    send_item(cllc_pkg::CMD_LOOKUP, 20'h7FFFF, 18'h20000, 8'd1);
    send_item(cllc_pkg::CMD_LOOKUP, 20'h00000, 18'h00000, 8'd200);
    send_item(cllc_pkg::CMD_LOOKUP, 20'hFFFFF, 18'h3FFFF, 8'd128);
    send_item(cllc_pkg::CMD_LOOKUP, 20'h01000, 18'h3FF00, 8'd255);
    send_item(cllc_pkg::CMD_LOOKUP, 20'h00800, 18'h00080, 8'd3);
    send_item(cllc_pkg::CMD_LOOKUP, 20'h80000, 18'h1FFFF, 8'd10);
    send_item(cllc_pkg::CMD_TIDY, 20'd0, 18'd0, 8'd0);
    send_item(cllc_pkg::CMD_TIDY, 20'hFFFFF, 18'h3FFFF, 8'hFF);
    send_item(cllc_pkg::CMD_LOOKUP, 20'h00800, 18'h00080, 8'd254);
    send_item(cllc_pkg::CMD_LOOKUP, cllc_pkg::SCALE_ONE, 18'd0, 8'd128);
    in_tvalid <= 1'b0;
  endtask

  // Mix of fresh keys (fills and evictions), reused keys, bypasses and tidies
  task automatic test_random(int unsigned count);
    int unsigned pick;
    int unsigned k;
    logic [31:0] rnd_sc;
    logic [31:0] rnd_off;
    logic [31:0] rnd_comp;
    logic [cllc_pkg::SCALE_W-1:0] sc;
    logic [cllc_pkg::OFFSET_W-1:0] off;
    logic [7:0] comp;
    for (int unsigned n = 0; n < count; n++) begin
      calm = (n >= 200 && n < 260);
      if (n == count / 2) drain_results();
      pick = $urandom_range(0, 99);
      rnd_sc = $urandom();
      rnd_off = $urandom();
      rnd_comp = $urandom();
      sc = rnd_sc[cllc_pkg::SCALE_W-1:0];
      off = rnd_off[cllc_pkg::OFFSET_W-1:0];
      comp = rnd_comp[7:0];
      if (pick < 36 && recent_scale.size() != 0) begin
        k = $urandom_range(0, recent_scale.size() - 1);
        send_item(cllc_pkg::CMD_LOOKUP, recent_scale[k], recent_offset[k], comp);
      end else if (pick < 42) begin
        send_item(cllc_pkg::CMD_LOOKUP, cllc_pkg::SCALE_ONE, 18'd0, comp);
      end else if (pick < 47) begin
        send_item(cllc_pkg::CMD_TIDY, sc, off, comp);
      end else begin
        send_item(cllc_pkg::CMD_LOOKUP, sc, off, comp);
      end
    end
    calm = 1'b0;
    in_tvalid <= 1'b0;
  endtask

  // Receiver back-pressure, free-running during the calm stretch
  always @(posedge clk)
    out_tready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 28);

  // Check accepted results; ready and valid are sampled away from the edge
  bit          o_v, o_r;
  logic [23:0] o_d;
  always @(negedge clk) begin
    o_v = out_tvalid;
    o_r = out_tready;
    o_d = out_tdata;
  end

  always @(posedge clk) begin
    lut_result_t got, want;
    if (rst_n && o_v && o_r) begin
      got = o_d[18:0];
      if (pending_results.size() == 0) begin
        $error("unexpected result %h", o_d);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.mapped_value !== want.mapped_value) begin
          $error("mapped_value expected %0d actual %0d", want.mapped_value, got.mapped_value);
          fail_count++;
        end
        if (got.status !== want.status) begin
          $error("status expected %0d actual %0d", want.status, got.status);
          fail_count++;
        end
        if (got.slot !== want.slot) begin
          $error("slot expected %0d actual %0d", want.slot, got.slot);
          fail_count++;
        end
        if (got.cleared !== want.cleared) begin
          $error("cleared expected %0d actual %0d", want.cleared, got.cleared);
          fail_count++;
        end
      end
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("clamped_linear_lut_cache_core verification failed");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < CAP; i++) cache_valid[i] = 1'b0;
    stamp_now = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(600);
    drain_results();
    repeat (600) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0)
      $display("clamped_linear_lut_cache_core verification clean");
    else
      $display("clamped_linear_lut_cache_core verification failed");
    $finish;
  end

endmodule
